// ----- rtl/core/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  // Field widths
  localparam int COMP_W    = 8;
  localparam int HUE_W     = 15;
  localparam int QUO_W     = 12;
  localparam int SAT_NUM_W = 16;
  localparam int HUE_NUM_W = 20;

  // Fixed-point constants, hue in 1/64 degree
  localparam logic [COMP_W-1:0] CMAX      = 8'd255;
  localparam logic [QUO_W-1:0]  HUE_SIXTH = 12'd3840;
  localparam logic [HUE_W-1:0]  HUE_FULL  = 15'd23040;
  localparam logic [HUE_W-1:0]  HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0]  HUE_BLUE  = 15'd15360;

  // Which component holds the maximum
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Side data that travels with each transaction through the divider
  typedef struct packed {
    logic              gray;
    sector_t           sector;
    logic              neg;
    logic [COMP_W-1:0] value;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/rhc_div_pipe.sv -----
// Pipelined restoring divider with two lanes, each with its own divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_pipe (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_vld,
  input  wire [rhc_pkg::SAT_NUM_W-1:0]    sat_num,
  input  wire [rhc_pkg::HUE_NUM_W-1:0]    hue_num,
  input  wire [rhc_pkg::COMP_W-1:0]       sat_den,
  input  wire [rhc_pkg::COMP_W-1:0]       den,
  input  rhc_pkg::tag_t                   in_tag,
  output logic                            out_vld,
  output logic [rhc_pkg::QUO_W-1:0]       sat_quo,
  output logic [rhc_pkg::QUO_W-1:0]       hue_quo,
  output rhc_pkg::tag_t                   out_tag
);

  localparam int QW     = rhc_pkg::QUO_W;
  localparam int DW     = rhc_pkg::COMP_W;
  localparam int SW     = rhc_pkg::SAT_NUM_W;
  localparam int HW     = rhc_pkg::HUE_NUM_W;
  localparam int SCMP_W = SW + DW;
  localparam int HCMP_W = HW + DW;

  // Stage registers, index s holds the result of stage s
  logic              vld_r     [QW];
  logic [SW-1:0]     sat_rem_r [QW];
  logic [HW-1:0]     hue_rem_r [QW];
  logic [QW-1:0]     sat_q_r   [QW];
  logic [QW-1:0]     hue_q_r   [QW];
  logic [DW-1:0]     sat_den_r [QW];
  logic [DW-1:0]     den_r     [QW];
  rhc_pkg::tag_t     tag_r     [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;

    logic          vld_in;
    logic [SW-1:0] sat_rem_in;
    logic [HW-1:0] hue_rem_in;
    logic [QW-1:0] sat_q_in;
    logic [QW-1:0] hue_q_in;
    logic [DW-1:0] sat_den_in;
    logic [DW-1:0] den_in;
    rhc_pkg::tag_t tag_in;

    logic [SCMP_W-1:0] sat_trial;
    logic [HCMP_W-1:0] hue_trial;
    logic              sat_ge;
    logic              hue_ge;
    logic [SW-1:0]     sat_rem_nxt;
    logic [HW-1:0]     hue_rem_nxt;

    // Select stage input: ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_first
      assign vld_in     = in_vld;
      assign sat_rem_in = sat_num;
      assign hue_rem_in = hue_num;
      assign sat_q_in   = '0;
      assign hue_q_in   = '0;
      assign sat_den_in = sat_den;
      assign den_in     = den;
      assign tag_in     = in_tag;
    end else begin : g_next
      assign vld_in     = vld_r[s-1];
      assign sat_rem_in = sat_rem_r[s-1];
      assign hue_rem_in = hue_rem_r[s-1];
      assign sat_q_in   = sat_q_r[s-1];
      assign hue_q_in   = hue_q_r[s-1];
      assign sat_den_in = sat_den_r[s-1];
      assign den_in     = den_r[s-1];
      assign tag_in     = tag_r[s-1];
    end

    // Try to subtract the divisor shifted to this quotient bit
    always_comb begin
      sat_trial   = SCMP_W'(sat_den_in) << K;
      hue_trial   = HCMP_W'(den_in) << K;
      sat_ge      = SCMP_W'(sat_rem_in) >= sat_trial;
      hue_ge      = HCMP_W'(hue_rem_in) >= hue_trial;
      sat_rem_nxt = sat_ge ? (sat_rem_in - sat_trial[SW-1:0]) : sat_rem_in;
      hue_rem_nxt = hue_ge ? (hue_rem_in - hue_trial[HW-1:0]) : hue_rem_in;
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    // Advance the payload, shifting the new quotient bit in from the bottom
    always_ff @(posedge clk) begin
      sat_rem_r[s] <= sat_rem_nxt;
      hue_rem_r[s] <= hue_rem_nxt;
      sat_q_r[s]   <= {sat_q_in[QW-2:0], sat_ge};
      hue_q_r[s]   <= {hue_q_in[QW-2:0], hue_ge};
      sat_den_r[s] <= sat_den_in;
      den_r[s]     <= den_in;
      tag_r[s]     <= tag_in;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign sat_quo = sat_q_r[QW-1];
  assign hue_quo = hue_q_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_convert.sv -----
// Top level of the RGB to HSV converter: sort, scale, divide and combine stages.
// Registers from start to the result: stage 1, stage 2, the divider stages and the output register;
// out_valid comes straight from the output register, which loads the divider result.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 12-stage restoring divider, one quotient bit per stage.
// Reset: rst_n (synchronous, active low) clears all valid bits; data registers keep contents.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_convert (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire [rhc_pkg::COMP_W-1:0]     in_red,
  input  wire [rhc_pkg::COMP_W-1:0]     in_green,
  input  wire [rhc_pkg::COMP_W-1:0]     in_blue,
  output logic                          out_valid,
  output logic [rhc_pkg::HUE_W-1:0]     out_hue,
  output logic [rhc_pkg::COMP_W-1:0]    out_saturation,
  output logic [rhc_pkg::COMP_W-1:0]    out_value
);

  localparam int CW = rhc_pkg::COMP_W;
  localparam int QW = rhc_pkg::QUO_W;
  localparam int HW = rhc_pkg::HUE_W;
  localparam int SW = rhc_pkg::SAT_NUM_W;
  localparam int NW = rhc_pkg::HUE_NUM_W;

  logic in_fire;

  // Stage 1: max, min, sector and signed difference
  logic              s1_vld_r;
  logic [CW-1:0]     s1_max_r;
  logic [CW-1:0]     s1_delta_r;
  logic [CW-1:0]     s1_diff_r;
  logic              s1_neg_r;
  rhc_pkg::sector_t  s1_sector_r;

  logic [CW-1:0]     max_nxt;
  logic [CW-1:0]     min_nxt;
  logic [CW-1:0]     op_a;
  logic [CW-1:0]     op_b;
  logic              neg_nxt;
  rhc_pkg::sector_t  sector_nxt;

  // Stage 2: scaled dividends
  logic              s2_vld_r;
  logic [SW-1:0]     s2_sat_num_r;
  logic [NW-1:0]     s2_hue_num_r;
  logic [CW-1:0]     s2_sat_den_r;
  logic [CW-1:0]     s2_den_r;
  rhc_pkg::tag_t     s2_tag_r;

  // Divider outputs
  logic              dv_vld;
  logic [QW-1:0]     dv_sat_q;
  logic [QW-1:0]     dv_hue_q;
  rhc_pkg::tag_t     dv_tag;

  // Output stage
  logic              out_vld_r;
  logic [HW-1:0]     out_hue_r;
  logic [CW-1:0]     out_sat_r;
  logic [CW-1:0]     out_val_r;
  logic [HW-1:0]     hue_nxt;
  logic [HW-1:0]     base;
  logic [HW-1:0]     offs;

  // Accept a transaction every cycle
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Sort components, red wins ties, then green
  always_comb begin
    max_nxt = in_red;
    min_nxt = in_red;
    if (in_green > max_nxt) max_nxt = in_green;
    if (in_blue  > max_nxt) max_nxt = in_blue;
    if (in_green < min_nxt) min_nxt = in_green;
    if (in_blue  < min_nxt) min_nxt = in_blue;

    if (in_red >= in_green && in_red >= in_blue) begin
      sector_nxt = rhc_pkg::SEC_RED;
      op_a       = in_green;
      op_b       = in_blue;
    end else if (in_green >= in_blue) begin
      sector_nxt = rhc_pkg::SEC_GREEN;
      op_a       = in_blue;
      op_b       = in_red;
    end else begin
      sector_nxt = rhc_pkg::SEC_BLUE;
      op_a       = in_red;
      op_b       = in_green;
    end
    neg_nxt = op_a < op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  // Hold magnitude of the difference and its sign
  always_ff @(posedge clk) begin
    s1_max_r    <= max_nxt;
    s1_delta_r  <= max_nxt - min_nxt;
    s1_diff_r   <= neg_nxt ? (op_b - op_a) : (op_a - op_b);
    s1_neg_r    <= neg_nxt;
    s1_sector_r <= sector_nxt;
  end

  // Scale numerators by constants
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sat_num_r    <= SW'(s1_delta_r) * SW'(rhc_pkg::CMAX);
    s2_hue_num_r    <= NW'(s1_diff_r) * NW'(rhc_pkg::HUE_SIXTH);
    s2_sat_den_r    <= s1_max_r;
    s2_den_r        <= s1_delta_r;
    s2_tag_r.gray   <= (s1_delta_r == '0);
    s2_tag_r.sector <= s1_sector_r;
    s2_tag_r.neg    <= s1_neg_r;
    s2_tag_r.value  <= s1_max_r;
  end

  // Divide saturation by max and hue by delta
  rhc_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s2_vld_r),
    .sat_num (s2_sat_num_r),
    .hue_num (s2_hue_num_r),
    .sat_den (s2_sat_den_r),
    .den     (s2_den_r),
    .in_tag  (s2_tag_r),
    .out_vld (dv_vld),
    .sat_quo (dv_sat_q),
    .hue_quo (dv_hue_q),
    .out_tag (dv_tag)
  );

  // Combine sector base and signed offset into hue
  always_comb begin
    offs = HW'(dv_hue_q);
    case (dv_tag.sector)
      rhc_pkg::SEC_RED:   base = dv_tag.neg ? rhc_pkg::HUE_FULL : '0;
      rhc_pkg::SEC_GREEN: base = rhc_pkg::HUE_GREEN;
      rhc_pkg::SEC_BLUE:  base = rhc_pkg::HUE_BLUE;
      default:            base = '0;
    endcase
    if (dv_tag.gray) begin
      hue_nxt = '0;
    end else if (dv_tag.neg) begin
      hue_nxt = base - offs;
    end else begin
      hue_nxt = base + offs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hue_r <= hue_nxt;
    out_sat_r <= dv_tag.gray ? '0 : dv_sat_q[CW-1:0];
    out_val_r <= dv_tag.value;
  end

  assign out_valid      = out_vld_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_val_r;

endmodule

`default_nettype wire

// ----- tb/sv/rgb_to_hsv_convert_tb.sv -----
// Self-checking testbench for the RGB to HSV converter: directed and random pixels.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_tb;

  localparam int CW          = rhc_pkg::COMP_W;
  localparam int HW          = rhc_pkg::HUE_W;
  localparam int FULL_CIRCLE = 23040;
  localparam int SIXTH       = 3840;
  localparam int GREEN_BASE  = 7680;
  localparam int BLUE_BASE   = 15360;
  localparam int COMP_MAX    = 255;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [HW-1:0] hue;
    logic [CW-1:0] saturation;
    logic [CW-1:0] value;
  } hsv_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [CW-1:0] in_red;
  logic [CW-1:0] in_green;
  logic [CW-1:0] in_blue;
  logic          out_valid;
  logic [HW-1:0] out_hue;
  logic [CW-1:0] out_saturation;
  logic [CW-1:0] out_value;

  hsv_t expected_hsv[$];
  int   mismatch_count = 0;
  int   stall_cycles   = 0;
  int   send_idle_pct  = 0;

  rgb_to_hsv_convert dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Compute the HSV triple of one pixel in 1/64 degree fixed point
  function automatic hsv_t predict_hsv(input logic [CW-1:0] r, g, b);
    hsv_t            res;
    int              ri, gi, bi, mx, mn, delta, hue, sat;
    rhc_pkg::sector_t sec;
    ri = r;
    gi = g;
    bi = b;
    // Ties go to red first, then green
    mx = ri;
    sec = rhc_pkg::SEC_RED;
    if (gi > mx) begin
      mx = gi;
      sec = rhc_pkg::SEC_GREEN;
    end
    if (bi > mx) begin
      mx = bi;
      sec = rhc_pkg::SEC_BLUE;
    end
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (delta != 0) begin
      sat = (COMP_MAX * delta) / mx;
      case (sec)
        rhc_pkg::SEC_RED: begin
          hue = ((gi - bi) * SIXTH) / delta;
          if (gi < bi) hue += FULL_CIRCLE;
        end
        rhc_pkg::SEC_GREEN: hue = GREEN_BASE + ((bi - ri) * SIXTH) / delta;
        default:            hue = BLUE_BASE + ((ri - gi) * SIXTH) / delta;
      endcase
      if (hue >= FULL_CIRCLE) hue -= FULL_CIRCLE;
      if (hue < 0) hue += FULL_CIRCLE;
    end
    res.hue        = hue[HW-1:0];
    res.saturation = sat[CW-1:0];
    res.value      = mx[CW-1:0];
    return res;
  endfunction

  // Predict on each accepted pixel, check each strobed result, watch for stalls
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n === 1'b1) begin
      stall_cycles++;
      if (start && !busy) begin
        expected_hsv.push_back(predict_hsv(in_red, in_green, in_blue));
        stall_cycles = 0;
      end
      if (out_valid !== 1'b0) begin
        stall_cycles = 0;
        if (expected_hsv.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("ERROR: unexpected result hue=%0d sat=%0d val=%0d",
                     out_hue, out_saturation, out_value);
        end else begin
          want = expected_hsv.pop_front();
          if (out_valid !== 1'b1 || out_hue !== want.hue
              || out_saturation !== want.saturation || out_value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("ERROR: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                       want.hue, want.saturation, want.value,
                       out_hue, out_saturation, out_value);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Send one pixel: idle at random, then hold start until the transaction is taken
  task automatic send_pixel(input logic [CW-1:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Extremes, gray pixels, pure and secondary colors, and max ties
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd254);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd200, 8'd50,  8'd50);
    send_pixel(8'd128, 8'd0,   8'd255);
    send_pixel(8'd170, 8'd85,  8'd255);
  endtask

  // Random pixels, biased toward gray, two-way ties and components of 0 or 255
  task automatic test_random_pixels(input int count, input int idle_pct);
    logic [CW-1:0] r, g, b;
    int            pick;
    send_idle_pct = idle_pct;
    repeat (count) begin
      r = CW'($urandom_range(255));
      g = CW'($urandom_range(255));
      b = CW'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 10) begin
        g = r;
        b = r;
      end else if (pick < 25) begin
        case ($urandom_range(2))
          0:       g = r;
          1:       b = r;
          default: b = g;
        endcase
      end else if (pick < 32) begin
        if ($urandom_range(1)) r = {CW{r[0]}};
        if ($urandom_range(1)) g = {CW{g[0]}};
        if ($urandom_range(1)) b = {CW{b[0]}};
      end
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 21;
    test_corner_pixels();
    test_random_pixels(670, 21);
    test_random_pixels(670, 65);
    test_random_pixels(670, 0);
    start = 1'b0;

    // Drain the pipeline, then keep watching for stray strobes
    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_hsv.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rhc_pkg.sv
rtl/core/rhc_div_pipe.sv
rtl/core/rgb_to_hsv_convert.sv
tb/sv/rgb_to_hsv_convert_tb.sv
